@@ rtl/thread_scheduler_with_semaphores_core_assert.svh @@
// Assertion macros for the scheduler RTL.
`ifndef THREAD_SCHEDULER_WITH_SEMAPHORES_CORE_ASSERT_SVH
`define THREAD_SCHEDULER_WITH_SEMAPHORES_CORE_ASSERT_SVH
// Implication checked at every clock edge outside reset.
`define TSS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define TSS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ rtl/tss_pkg.sv @@
package tss_pkg;

    localparam int MAX_THREADS_DEF    = 16;
    localparam int NUM_SEMAPHORES_DEF = 8;

    typedef enum logic [2:0] {
        OP_INIT   = 3'd0,
        OP_CREATE = 3'd1,
        OP_YIELD  = 3'd2,
        OP_LOCK   = 3'd3,
        OP_UNLOCK = 3'd4,
        OP_EXIT   = 3'd5
    } opcode_t;

    typedef enum logic [2:0] {
        TS_UNUSED   = 3'd0,
        TS_RUNNING  = 3'd1,
        TS_READY    = 3'd2,
        TS_BLOCKED  = 3'd3,
        TS_FINISHED = 3'd4
    } tstat_t;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_HALT = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_ROT,
        S_FIFO,
        S_DONE
    } state_t;

endpackage

@@ rtl/thread_scheduler_with_semaphores_core.sv @@
// Thread scheduler with counting semaphores.
// A command beat is accepted when start is high and busy is low; opcode,
// sem_index and init_count are sampled then. busy stays high until the result
// is shown. The result appears for exactly one cycle with done high; the
// receiver cannot stall it, so it must take the beat in that cycle.
// Init, create and non-blocking lock go from accept through S_DONE to done.
// Unlock with waiters also passes through S_FIFO (one registered read of the
// wait FIFO memory). Yield, blocking lock and exit scan the thread order one
// entry a cycle through a single compare unit, up to the whole order length;
// yield then rotates the current thread to the queue end, one entry a cycle.
// With 16 threads the worst case is a yield. busy is low in the done cycle, so
// the next command can be accepted at the edge that ends it.
// Reset puts thread 0 running alone in the queue, clears all semaphores, and
// leaves the wait FIFO memory unwritten; no clearing pass is needed because
// entries are read only after being written.
module thread_scheduler_with_semaphores_core #(
    parameter int MAX_THREADS    = tss_pkg::MAX_THREADS_DEF,
    parameter int NUM_SEMAPHORES = tss_pkg::NUM_SEMAPHORES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [2:0] opcode,
    input  logic [2:0] sem_index,
    input  logic [7:0] init_count,
    output logic       done,
    output logic [1:0] status,
    output logic [3:0] running_thread,
    output logic       switched,
    output logic [3:0] new_thread,
    output logic       woken_valid,
    output logic [3:0] woken_thread
);
    import tss_pkg::*;
    `include "thread_scheduler_with_semaphores_core_assert.svh"

    localparam int TW = $clog2(MAX_THREADS);
    localparam int LW = $clog2(MAX_THREADS + 1);
    localparam int SW = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1;
    localparam int FD = NUM_SEMAPHORES * MAX_THREADS;
    localparam int FW = $clog2(FD);

    // Thread table and order queue.
    tstat_t            tstat_reg [MAX_THREADS];
    tstat_t            tstat_next [MAX_THREADS];
    logic [TW-1:0]     queue_reg [MAX_THREADS];
    logic [TW-1:0]     queue_next [MAX_THREADS];
    logic [LW-1:0]     qlen_reg;
    logic [LW-1:0]     qlen_next;
    logic [TW-1:0]     cur_reg;
    logic [TW-1:0]     cur_next;
    logic [LW-1:0]     next_id_reg;
    logic [LW-1:0]     next_id_next;

    // Semaphore state.
    logic signed [8:0] cnt_reg [NUM_SEMAPHORES];
    logic signed [8:0] cnt_next [NUM_SEMAPHORES];
    logic              lck_reg [NUM_SEMAPHORES];
    logic              lck_next [NUM_SEMAPHORES];
    logic [LW-1:0]     wcnt_reg [NUM_SEMAPHORES];
    logic [LW-1:0]     wcnt_next [NUM_SEMAPHORES];
    logic [TW-1:0]     whead_reg [NUM_SEMAPHORES];
    logic [TW-1:0]     whead_next [NUM_SEMAPHORES];
    logic [TW-1:0]     wtail_reg [NUM_SEMAPHORES];
    logic [TW-1:0]     wtail_next [NUM_SEMAPHORES];
    logic [TW-1:0]     fifo_mem [FD];
    logic [TW-1:0]     fifo_rd_reg;

    // Command and sequencer registers.
    state_t            st_reg;
    state_t            st_next;
    opcode_t           op_reg;
    opcode_t           op_next;
    logic [2:0]        sidx_reg;
    logic [2:0]        sidx_next;
    logic [7:0]        ic_reg;
    logic [7:0]        ic_next;
    logic [LW-1:0]     idx_reg;
    logic [LW-1:0]     idx_next;

    // Result registers.
    logic              done_reg;
    logic              done_next;
    logic [1:0]        status_reg;
    logic [1:0]        status_next;
    logic              sw_reg;
    logic              sw_next;
    logic [3:0]        newt_reg;
    logic [3:0]        newt_next;
    logic              wv_reg;
    logic              wv_next;
    logic [3:0]        wt_reg;
    logic [3:0]        wt_next;

    logic              sem_ok;
    logic [SW-1:0]     si;
    logic              accept;
    logic [TW-1:0]     scan_t;
    logic [TW-1:0]     idx_t;
    logic [TW-1:0]     idx1_t;
    logic              idx_last;

    assign accept   = start && (st_reg == S_IDLE);
    assign busy     = (st_reg != S_IDLE);
    assign sem_ok   = {29'd0, sidx_reg} < NUM_SEMAPHORES;
    assign si       = SW'(sidx_reg);
    assign idx_t    = idx_reg[TW-1:0];
    assign idx1_t   = TW'(idx_reg + LW'(1));
    assign scan_t   = queue_reg[idx_t];
    assign idx_last = (idx_reg + LW'(1)) >= qlen_reg;

    assign done           = done_reg;
    assign status         = status_reg;
    assign running_thread = 4'(cur_reg);
    assign switched       = sw_reg;
    assign new_thread     = newt_reg;
    assign woken_valid    = wv_reg;
    assign woken_thread   = wt_reg;

    // Wait FIFO memory: written on a blocking lock, read for unlock.
    always_ff @(posedge clk)
    begin
        if (st_reg == S_SCAN && op_reg == OP_LOCK && tstat_reg[scan_t] == TS_READY
            && wcnt_reg[si] < LW'(MAX_THREADS))
        begin
            fifo_mem[FW'(si) * FW'(MAX_THREADS) + FW'(wtail_reg[si])] <= cur_reg;
        end
        fifo_rd_reg <= fifo_mem[FW'(si) * FW'(MAX_THREADS) + FW'(whead_reg[si])];
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_THREADS; i++)
            begin
                tstat_reg[i] <= (i == 0) ? TS_RUNNING : TS_UNUSED;
                queue_reg[i] <= '0;
            end
            for (int i = 0; i < NUM_SEMAPHORES; i++)
            begin
                cnt_reg[i]   <= '0;
                lck_reg[i]   <= 1'b0;
                wcnt_reg[i]  <= '0;
                whead_reg[i] <= '0;
                wtail_reg[i] <= '0;
            end
            qlen_reg    <= LW'(1);
            cur_reg     <= '0;
            next_id_reg <= LW'(1);
            st_reg      <= S_IDLE;
            op_reg      <= OP_INIT;
            sidx_reg    <= '0;
            ic_reg      <= '0;
            idx_reg     <= '0;
            done_reg    <= 1'b0;
            status_reg  <= STATUS_OK;
            sw_reg      <= 1'b0;
            newt_reg    <= '0;
            wv_reg      <= 1'b0;
            wt_reg      <= '0;
        end
        else
        begin
            tstat_reg   <= tstat_next;
            queue_reg   <= queue_next;
            cnt_reg     <= cnt_next;
            lck_reg     <= lck_next;
            wcnt_reg    <= wcnt_next;
            whead_reg   <= whead_next;
            wtail_reg   <= wtail_next;
            qlen_reg    <= qlen_next;
            cur_reg     <= cur_next;
            next_id_reg <= next_id_next;
            st_reg      <= st_next;
            op_reg      <= op_next;
            sidx_reg    <= sidx_next;
            ic_reg      <= ic_next;
            idx_reg     <= idx_next;
            done_reg    <= done_next;
            status_reg  <= status_next;
            sw_reg      <= sw_next;
            newt_reg    <= newt_next;
            wv_reg      <= wv_next;
            wt_reg      <= wt_next;
        end
    end

    // Sequencer: next state and state updates.
    always_comb
    begin
        tstat_next   = tstat_reg;
        queue_next   = queue_reg;
        cnt_next     = cnt_reg;
        lck_next     = lck_reg;
        wcnt_next    = wcnt_reg;
        whead_next   = whead_reg;
        wtail_next   = wtail_reg;
        qlen_next    = qlen_reg;
        cur_next     = cur_reg;
        next_id_next = next_id_reg;
        st_next      = st_reg;
        op_next      = op_reg;
        sidx_next    = sidx_reg;
        ic_next      = ic_reg;
        idx_next     = idx_reg;
        done_next    = 1'b0;
        status_next  = status_reg;
        sw_next      = sw_reg;
        newt_next    = newt_reg;
        wv_next      = wv_reg;
        wt_next      = wt_reg;
        unique case (st_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next     = opcode_t'(opcode);
                    sidx_next   = sem_index;
                    ic_next     = init_count;
                    idx_next    = '0;
                    status_next = STATUS_OK;
                    sw_next     = 1'b0;
                    newt_next   = '0;
                    wv_next     = 1'b0;
                    wt_next     = '0;
                    if (opcode == OP_YIELD || opcode == OP_EXIT)
                    begin
                        st_next = S_SCAN;
                    end
                    else
                    begin
                        st_next = S_DONE;
                    end
                end
            end
            S_SCAN:
            begin
                // One queue entry is compared each cycle.
                if (tstat_reg[scan_t] == TS_READY)
                begin
                    if (op_reg == OP_YIELD)
                    begin
                        tstat_next[cur_reg] = TS_READY;
                        tstat_next[scan_t]  = TS_RUNNING;
                        cur_next = scan_t;
                        sw_next  = 1'b1;
                        // Remember the old thread id for the rotation.
                        ic_next  = {1'b0, 7'(cur_reg)};
                        idx_next = '0;
                        st_next  = S_ROT;
                    end
                    else if (op_reg == OP_EXIT)
                    begin
                        tstat_next[cur_reg] = TS_FINISHED;
                        tstat_next[scan_t]  = TS_RUNNING;
                        cur_next  = scan_t;
                        sw_next   = 1'b1;
                        done_next = 1'b1;
                        st_next   = S_IDLE;
                    end
                    else if (wcnt_reg[si] >= LW'(MAX_THREADS))
                    begin
                        status_next = STATUS_HALT;
                        done_next   = 1'b1;
                        st_next     = S_IDLE;
                    end
                    else
                    begin
                        tstat_next[cur_reg] = TS_BLOCKED;
                        tstat_next[scan_t]  = TS_RUNNING;
                        cur_next = scan_t;
                        sw_next  = 1'b1;
                        wtail_next[si] = (wtail_reg[si] == TW'(MAX_THREADS - 1))
                            ? '0 : wtail_reg[si] + TW'(1);
                        wcnt_next[si] = wcnt_reg[si] + LW'(1);
                        done_next = 1'b1;
                        st_next   = S_IDLE;
                    end
                end
                else if (idx_last)
                begin
                    status_next = STATUS_HALT;
                    done_next   = 1'b1;
                    st_next     = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + LW'(1);
                end
            end
            S_ROT:
            begin
                // Find the old thread, then swap it one entry toward the end per cycle.
                if (idx_last)
                begin
                    done_next = 1'b1;
                    st_next   = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + LW'(1);
                    if (queue_reg[idx_t] == TW'(ic_reg) || ic_reg[7])
                    begin
                        ic_next[7]         = 1'b1;
                        queue_next[idx_t]  = queue_reg[idx1_t];
                        queue_next[idx1_t] = queue_reg[idx_t];
                    end
                end
            end
            S_FIFO:
            begin
                tstat_next[fifo_rd_reg] = TS_READY;
                wv_next   = 1'b1;
                wt_next   = 4'(fifo_rd_reg);
                done_next = 1'b1;
                st_next   = S_IDLE;
            end
            S_DONE:
            begin
                done_next = 1'b1;
                st_next   = S_IDLE;
                unique case (op_reg)
                    OP_INIT:
                    begin
                        if (sem_ok)
                        begin
                            cnt_next[si]   = $signed({1'b0, ic_reg});
                            lck_next[si]   = 1'b0;
                            wcnt_next[si]  = '0;
                            whead_next[si] = '0;
                            wtail_next[si] = '0;
                        end
                    end
                    OP_CREATE:
                    begin
                        if (next_id_reg >= LW'(MAX_THREADS) || qlen_reg >= LW'(MAX_THREADS))
                        begin
                            status_next = STATUS_FULL;
                        end
                        else
                        begin
                            newt_next = 4'(next_id_reg);
                            tstat_next[TW'(next_id_reg)] = TS_READY;
                            queue_next[TW'(qlen_reg)] = TW'(next_id_reg);
                            qlen_next    = qlen_reg + LW'(1);
                            next_id_next = next_id_reg + LW'(1);
                        end
                    end
                    OP_LOCK:
                    begin
                        if (sem_ok && !lck_reg[si])
                        begin
                            cnt_next[si] = (cnt_reg[si] == -9'sd256) ? cnt_reg[si]
                                : cnt_reg[si] - 9'sd1;
                            if (cnt_reg[si] <= 9'sd1)
                            begin
                                lck_next[si] = 1'b1;
                            end
                        end
                        else if (sem_ok)
                        begin
                            done_next = 1'b0;
                            idx_next  = '0;
                            st_next   = S_SCAN;
                        end
                    end
                    OP_UNLOCK:
                    begin
                        if (sem_ok && wcnt_reg[si] != '0)
                        begin
                            whead_next[si] = (whead_reg[si] == TW'(MAX_THREADS - 1))
                                ? '0 : whead_reg[si] + TW'(1);
                            wcnt_next[si] = wcnt_reg[si] - LW'(1);
                            done_next = 1'b0;
                            st_next   = S_FIFO;
                        end
                        else if (sem_ok)
                        begin
                            lck_next[si] = 1'b0;
                            if (cnt_reg[si] < 9'sd255)
                            begin
                                cnt_next[si] = cnt_reg[si] + 9'sd1;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    // Checks on the sequencer.
    `TSS_ASSERT_IMP(a_done_idle, clk, rst_n, done, !busy)
    `TSS_ASSERT_NXT(a_accept_busy, clk, rst_n, accept, busy)
    `TSS_ASSERT_IMP(a_sw_ok, clk, rst_n, done && switched, status == STATUS_OK)
    `TSS_ASSERT_IMP(a_wake_ok, clk, rst_n, done && woken_valid, !switched)

endmodule

@@ tb/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import tss_pkg::*;

    localparam int NTHR       = MAX_THREADS_DEF;
    localparam int NSEM       = NUM_SEMAPHORES_DEF;
    localparam int RAND_ITEMS = 700;
    localparam int STALL_MAX  = 3000;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] running_thread;
        logic       switched;
        logic [3:0] new_thread;
        logic       woken_valid;
        logic [3:0] woken_thread;
    } sched_res_t;

    typedef struct {
        logic [2:0] op;
        logic [2:0] sem;
        logic [7:0] cnt;
        bit         typed;
        sched_res_t res;
    } cmd_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    logic [2:0] opcode = '0;
    logic [2:0] sem_index = '0;
    logic [7:0] init_count = '0;
    logic       done;
    logic [1:0] status;
    logic [3:0] running_thread;
    logic       switched;
    logic [3:0] new_thread;
    logic       woken_valid;
    logic [3:0] woken_thread;

    thread_scheduler_with_semaphores_core u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .opcode(opcode), .sem_index(sem_index), .init_count(init_count),
        .done(done), .status(status), .running_thread(running_thread),
        .switched(switched), .new_thread(new_thread),
        .woken_valid(woken_valid), .woken_thread(woken_thread)
    );

    always #1 clk = ~clk;

    // Scheduler shadow state.
    tstat_t     thr_state [NTHR];
    logic [3:0] run_order [NTHR];
    int         order_len;
    int         cur_thr;
    int         next_id;
    int         sem_cnt [NSEM];
    bit         sem_held [NSEM];
    int         sem_wait_cnt [NSEM];
    logic [3:0] sem_wait_q [NSEM][NTHR];
    int         wq_head [NSEM];
    int         wq_tail [NSEM];

    sched_res_t pending_res [$];
    int         fail_count = 0;
    int         idle_cycles = 0;

    task automatic sched_reset();
        for (int i = 0; i < NTHR; i++)
        begin
            thr_state[i] = TS_UNUSED;
            run_order[i] = '0;
        end
        for (int i = 0; i < NSEM; i++)
        begin
            sem_cnt[i] = 0;
            sem_held[i] = 0;
            sem_wait_cnt[i] = 0;
            wq_head[i] = 0;
            wq_tail[i] = 0;
        end
        thr_state[0] = TS_RUNNING;
        order_len = 1;
        cur_thr = 0;
        next_id = 1;
    endtask

    function automatic int first_ready();
        for (int i = 0; i < order_len && i < NTHR; i++)
        begin
            if (thr_state[run_order[i]] == TS_READY)
                return int'(run_order[i]);
        end
        return -1;
    endfunction

    // Rotate the current thread to the end of the order.
    task automatic rotate_current();
        int pos;
        pos = -1;
        for (int i = 0; i < order_len; i++)
        begin
            if (pos < 0 && run_order[i] == cur_thr)
                pos = i;
        end
        if (pos >= 0)
        begin
            for (int i = pos; i + 1 < order_len; i++)
                run_order[i] = run_order[i + 1];
            run_order[order_len - 1] = cur_thr[3:0];
        end
    endtask

    task automatic sched_apply(input logic [2:0] op, input logic [2:0] s,
                               input logic [7:0] ic, output sched_res_t r);
        int nx;
        int t;
        r = '0;
        case (op)
            OP_INIT:
            begin
                sem_cnt[s] = ic;
                sem_held[s] = 0;
                sem_wait_cnt[s] = 0;
                wq_head[s] = 0;
                wq_tail[s] = 0;
            end
            OP_CREATE:
            begin
                if (next_id >= NTHR || order_len >= NTHR)
                    r.status = STATUS_FULL;
                else
                begin
                    r.new_thread = next_id[3:0];
                    thr_state[next_id] = TS_READY;
                    run_order[order_len] = next_id[3:0];
                    order_len++;
                    next_id++;
                end
            end
            OP_YIELD:
            begin
                nx = first_ready();
                if (nx < 0)
                    r.status = STATUS_HALT;
                else
                begin
                    thr_state[cur_thr] = TS_READY;
                    rotate_current();
                    thr_state[nx] = TS_RUNNING;
                    cur_thr = nx;
                    r.switched = 1'b1;
                end
            end
            OP_LOCK:
            begin
                if (!sem_held[s])
                begin
                    sem_cnt[s]--;
                    if (sem_cnt[s] < -256)
                        sem_cnt[s] = -256;
                    if (sem_cnt[s] <= 0)
                        sem_held[s] = 1;
                end
                else
                begin
                    nx = first_ready();
                    if (nx < 0 || sem_wait_cnt[s] >= NTHR)
                        r.status = STATUS_HALT;
                    else
                    begin
                        thr_state[cur_thr] = TS_BLOCKED;
                        sem_wait_q[s][wq_tail[s]] = cur_thr[3:0];
                        wq_tail[s] = (wq_tail[s] + 1) % NTHR;
                        sem_wait_cnt[s]++;
                        thr_state[nx] = TS_RUNNING;
                        cur_thr = nx;
                        r.switched = 1'b1;
                    end
                end
            end
            OP_UNLOCK:
            begin
                if (sem_wait_cnt[s] != 0)
                begin
                    t = sem_wait_q[s][wq_head[s]];
                    wq_head[s] = (wq_head[s] + 1) % NTHR;
                    sem_wait_cnt[s]--;
                    thr_state[t] = TS_READY;
                    r.woken_valid = 1'b1;
                    r.woken_thread = t[3:0];
                end
                else
                begin
                    sem_held[s] = 0;
                    if (sem_cnt[s] < 255)
                        sem_cnt[s]++;
                end
            end
            OP_EXIT:
            begin
                nx = first_ready();
                if (nx < 0)
                    r.status = STATUS_HALT;
                else
                begin
                    thr_state[cur_thr] = TS_FINISHED;
                    thr_state[nx] = TS_RUNNING;
                    cur_thr = nx;
                    r.switched = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        r.running_thread = cur_thr[3:0];
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // Result beats are compared with the oldest pending prediction.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_res.size() == 0)
                report_mismatch("unexpected result beat", 1, 0);
            else
            begin
                sched_res_t w;
                w = pending_res.pop_front();
                if (status !== w.status)
                    report_mismatch("status", status, w.status);
                if (running_thread !== w.running_thread)
                    report_mismatch("running_thread", running_thread, w.running_thread);
                if (switched !== w.switched)
                    report_mismatch("switched", switched, w.switched);
                if (new_thread !== w.new_thread)
                    report_mismatch("new_thread", new_thread, w.new_thread);
                if (woken_valid !== w.woken_valid)
                    report_mismatch("woken_valid", woken_valid, w.woken_valid);
                if (woken_thread !== w.woken_thread)
                    report_mismatch("woken_thread", woken_thread, w.woken_thread);
            end
        end
    end

    // Watchdog on cycles with no accepted beat on either side.
    always @(posedge clk)
    begin
        if (done || (start && !busy))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_MAX)
        begin
            $display("thread_scheduler_with_semaphores_core verification failed");
            $finish;
        end
    end

    // Drive one command beat after a gap and wait until it is taken.
    task automatic send_cmd(input logic [2:0] op, input logic [2:0] s,
                            input logic [7:0] ic, input int gap,
                            input bit typed, input sched_res_t typed_res);
        sched_res_t r;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        opcode <= op;
        sem_index <= s;
        init_count <= ic;
        start <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        sched_apply(op, s, ic, r);
        pending_res.push_back(typed ? typed_res : r);
        @(negedge clk);
    endtask

    function automatic sched_res_t mk(input logic [1:0] st, input int run, input bit sw,
                                      input int nt, input bit wv, input int wt);
        sched_res_t r;
        r.status = st;
        r.running_thread = run[3:0];
        r.switched = sw;
        r.new_thread = nt[3:0];
        r.woken_valid = wv;
        r.woken_thread = wt[3:0];
        return r;
    endfunction

    function automatic logic [2:0] pick_op();
        int p;
        p = $urandom_range(0, 99);
        if (p < 8)  return OP_INIT;
        if (p < 18) return OP_CREATE;
        if (p < 43) return OP_YIELD;
        if (p < 68) return OP_LOCK;
        if (p < 94) return OP_UNLOCK;
        if (p < 98) return OP_EXIT;
        return 3'($urandom_range(6, 7));
    endfunction

    cmd_row_t dir_rows [$];

    initial
    begin
        logic [2:0] op;
        logic [2:0] s;
        logic [7:0] ic;
        int         gap;
        bit         burst;
        sched_res_t none;

        none = '0;
        sched_reset();
        // Directed commands: halts from reset, saturation, unused opcodes, hand-over.
        dir_rows.push_back('{OP_YIELD,  3'd0, 8'd0,   1, mk(STATUS_HALT, 0, 0, 0, 0, 0)});
        dir_rows.push_back('{OP_EXIT,   3'd0, 8'd0,   1, mk(STATUS_HALT, 0, 0, 0, 0, 0)});
        dir_rows.push_back('{OP_LOCK,   3'd0, 8'd0,   1, mk(STATUS_OK,   0, 0, 0, 0, 0)});
        dir_rows.push_back('{OP_LOCK,   3'd0, 8'd0,   1, mk(STATUS_HALT, 0, 0, 0, 0, 0)});
        dir_rows.push_back('{OP_UNLOCK, 3'd0, 8'd0,   1, mk(STATUS_OK,   0, 0, 0, 0, 0)});
        dir_rows.push_back('{OP_INIT,   3'd7, 8'd255, 1, mk(STATUS_OK,   0, 0, 0, 0, 0)});
        dir_rows.push_back('{OP_UNLOCK, 3'd7, 8'd0,   1, mk(STATUS_OK,   0, 0, 0, 0, 0)});
        dir_rows.push_back('{3'd6,      3'd5, 8'd170, 1, mk(STATUS_OK,   0, 0, 0, 0, 0)});
        dir_rows.push_back('{3'd7,      3'd2, 8'd85,  1, mk(STATUS_OK,   0, 0, 0, 0, 0)});
        dir_rows.push_back('{OP_CREATE, 3'd0, 8'd0,   1, mk(STATUS_OK,   0, 0, 1, 0, 0)});
        dir_rows.push_back('{OP_CREATE, 3'd0, 8'd0,   1, mk(STATUS_OK,   0, 0, 2, 0, 0)});
        dir_rows.push_back('{OP_YIELD,  3'd0, 8'd0,   1, mk(STATUS_OK,   1, 1, 0, 0, 0)});
        dir_rows.push_back('{OP_LOCK,   3'd0, 8'd0,   1, mk(STATUS_OK,   1, 0, 0, 0, 0)});
        dir_rows.push_back('{OP_LOCK,   3'd0, 8'd0,   1, mk(STATUS_OK,   2, 1, 0, 0, 0)});
        dir_rows.push_back('{OP_UNLOCK, 3'd0, 8'd0,   1, mk(STATUS_OK,   2, 0, 0, 1, 1)});
        dir_rows.push_back('{OP_INIT,   3'd3, 8'd0,   0, none});
        dir_rows.push_back('{OP_LOCK,   3'd3, 8'd0,   0, none});
        dir_rows.push_back('{OP_LOCK,   3'd3, 8'd0,   0, none});
        dir_rows.push_back('{OP_EXIT,   3'd0, 8'd0,   0, none});
        dir_rows.push_back('{OP_YIELD,  3'd0, 8'd0,   0, none});
        dir_rows.push_back('{OP_UNLOCK, 3'd3, 8'd0,   0, none});
        dir_rows.push_back('{OP_INIT,   3'd4, 8'd128, 0, none});
        dir_rows.push_back('{OP_INIT,   3'd5, 8'd127, 0, none});

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
            send_cmd(dir_rows[i].op, dir_rows[i].sem, dir_rows[i].cnt,
                     $urandom_range(0, 11), dir_rows[i].typed, dir_rows[i].res);

        // Random commands, mostly contending on a few semaphores.
        burst = 0;
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            if (n % 40 == 0)
                burst = ($urandom_range(0, 3) == 0);
            op = pick_op();
            s = ($urandom_range(0, 3) != 0) ? 3'($urandom_range(0, 2)) : 3'($urandom);
            if ($urandom_range(0, 4) == 0)
                ic = 8'($urandom);
            else
                ic = 8'($urandom_range(0, 3));
            gap = burst ? 0 : $urandom_range(0, 11);
            send_cmd(op, s, ic, gap, 0, none);
        end
        start <= 1'b0;

        while (pending_res.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("thread_scheduler_with_semaphores_core verification clean");
        else
            $display("thread_scheduler_with_semaphores_core verification failed");
        $finish;
    end
endmodule
